### rtl/threshold_qgram_profile_distance_macros.svh
// Assertion macros used by the datapath RTL of the q-gram profile distance block.
`ifndef THRESHOLD_QGRAM_PROFILE_DISTANCE_MACROS_SVH
`define THRESHOLD_QGRAM_PROFILE_DISTANCE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TQPD_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TQPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/tqpd_pkg.sv
//------------------------------------------------------------------------------
// tqpd_pkg
// Shared constants, codes and controller/datapath interface structs.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package tqpd_pkg;
	localparam int MAX_ENTRIES_DEF   = 1024;
	localparam int MAX_THRESHOLD_DEF = 6;

	localparam int KEY_W   = 64;
	localparam int THR_W   = 3;
	localparam int STAT_W  = 2;
	localparam int TOT_W   = 11;
	localparam int BCNT_W  = 3;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [THR_W-1:0] THRESHOLD_RESET = 3'd2;
	localparam logic [PADDR_W-1:0] ADDR_THRESHOLD = 3'd0;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REPORT = 1'b1;
	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_BIN    = 1'b1;

	localparam logic [STAT_W-1:0] INS_NEW  = 2'd0;
	localparam logic [STAT_W-1:0] INS_HIT  = 2'd1;
	localparam logic [STAT_W-1:0] INS_FULL = 2'd2;

	typedef struct packed {
		logic init_wr;
		logic ins_start;
		logic slot_rd;
		logic ent_rd_probe;
		logic probe_eval;
		logic ins_out;
		logic rpt_start;
		logic clr;
		logic walk_rd;
		logic walk_bin;
		logic hist_rd;
		logic walk_wr;
		logic emit_out;
	} cmd_t;

	typedef struct packed {
		logic init_done;
		logic occupied;
		logic hit;
		logic empty;
		logic clr_done;
		logic walk_done;
		logic out_free;
		logic emit_last;
	} sts_t;
endpackage
`default_nettype wire

### rtl/tqpd_if.sv
//------------------------------------------------------------------------------
// tqpd_in_if / tqpd_out_if
// Valid/ready channels carrying the input items and the result items.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface tqpd_in_if;
	logic valid;
	logic ready;
	logic operation;
	logic [tqpd_pkg::KEY_W-1:0] qgram_key;
	logic second_string;
	modport source (output valid, operation, qgram_key, second_string, input ready);
	modport sink (input valid, operation, qgram_key, second_string, output ready);
endinterface

interface tqpd_out_if;
	logic valid;
	logic ready;
	logic result_kind;
	logic [tqpd_pkg::STAT_W-1:0] insert_status;
	logic [tqpd_pkg::TOT_W-1:0] distance;
	logic [tqpd_pkg::TOT_W-1:0] entry_count;
	logic [tqpd_pkg::BCNT_W-1:0] bin_first_count;
	logic [tqpd_pkg::BCNT_W-1:0] bin_second_count;
	logic [tqpd_pkg::TOT_W-1:0] bin_total;
	logic last;
	modport source (output valid, result_kind, insert_status, distance, entry_count,
		bin_first_count, bin_second_count, bin_total, last, input ready);
	modport sink (input valid, result_kind, insert_status, distance, entry_count,
		bin_first_count, bin_second_count, bin_total, last, output ready);
endinterface
`default_nettype wire

### rtl/tqpd_ctrl.sv
//------------------------------------------------------------------------------
// tqpd_ctrl
// Sequencer for slot table init, insert probing, histogram clear, entry walk and bin emission.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tqpd_ctrl (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire logic in_op,
	output logic in_ready,
	input  wire tqpd_pkg::sts_t sts,
	output tqpd_pkg::cmd_t cmd
);
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_HRD  = 4'd1;
	localparam logic [3:0] S_HCHK = 4'd2;
	localparam logic [3:0] S_ECHK = 4'd3;
	localparam logic [3:0] S_IOUT = 4'd4;
	localparam logic [3:0] S_CLR  = 4'd5;
	localparam logic [3:0] S_WRD  = 4'd6;
	localparam logic [3:0] S_WBIN = 4'd7;
	localparam logic [3:0] S_WHRD = 4'd8;
	localparam logic [3:0] S_WWR  = 4'd9;
	localparam logic [3:0] S_ERD  = 4'd10;
	localparam logic [3:0] S_EOUT = 4'd11;
	localparam logic [3:0] S_INIT = 4'd12;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			S_INIT: begin
				// Every slot gets a defined pointer before the first lookup.
				cmd.init_wr = 1'b1;
				if (sts.init_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_op == tqpd_pkg::OP_INSERT) begin
						cmd.ins_start = 1'b1;
						state_d = S_HRD;
					end else begin
						cmd.rpt_start = 1'b1;
						state_d = S_CLR;
					end
				end
			end
			S_HRD: begin
				cmd.slot_rd = 1'b1;
				state_d = S_HCHK;
			end
			S_HCHK: begin
				cmd.ent_rd_probe = 1'b1;
				state_d = S_ECHK;
			end
			S_ECHK: begin
				cmd.probe_eval = 1'b1;
				state_d = (sts.occupied && !sts.hit) ? S_HRD : S_IOUT;
			end
			S_IOUT: begin
				if (sts.out_free) begin
					cmd.ins_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_CLR: begin
				cmd.clr = 1'b1;
				if (sts.clr_done) state_d = sts.empty ? S_ERD : S_WRD;
			end
			S_WRD: begin
				cmd.walk_rd = 1'b1;
				state_d = S_WBIN;
			end
			S_WBIN: begin
				cmd.walk_bin = 1'b1;
				state_d = S_WHRD;
			end
			S_WHRD: begin
				cmd.hist_rd = 1'b1;
				state_d = S_WWR;
			end
			S_WWR: begin
				cmd.walk_wr = 1'b1;
				state_d = sts.walk_done ? S_ERD : S_WRD;
			end
			S_ERD: begin
				cmd.hist_rd = 1'b1;
				state_d = S_EOUT;
			end
			S_EOUT: begin
				if (sts.out_free) begin
					cmd.emit_out = 1'b1;
					state_d = sts.emit_last ? S_IDLE : S_ERD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_INIT;
		else state_q <= state_d;
	end
endmodule
`default_nettype wire

### rtl/tqpd_dp.sv
//------------------------------------------------------------------------------
// tqpd_dp
// Hash slot table, dense entry memory, histogram memory and result register.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "threshold_qgram_profile_distance_macros.svh"
module tqpd_dp #(
	parameter int MAX_ENTRIES   = tqpd_pkg::MAX_ENTRIES_DEF,
	parameter int MAX_THRESHOLD = tqpd_pkg::MAX_THRESHOLD_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire tqpd_pkg::cmd_t cmd,
	output tqpd_pkg::sts_t sts,
	input  wire logic [$clog2(MAX_THRESHOLD+1)-1:0] thr,
	input  wire logic [tqpd_pkg::KEY_W-1:0] in_key,
	input  wire logic in_second,
	tqpd_out_if.source out_ch
);
	localparam int IW  = $clog2(MAX_ENTRIES);
	localparam int NW  = IW + 1;
	localparam int SW  = IW + 1;
	localparam int CW  = $clog2(MAX_THRESHOLD + 2);
	localparam int SDW = $clog2(MAX_THRESHOLD + 3);
	localparam int NB  = (MAX_THRESHOLD + 2) * (MAX_THRESHOLD + 2);
	localparam int BW  = $clog2(NB);
	localparam int KW  = tqpd_pkg::KEY_W;
	localparam int NCH = (KW + SW - 1) / SW;

	typedef struct packed {
		logic [KW-1:0] key;
		logic [SW-1:0] slot;
		logic [CW-1:0] fc;
		logic [CW-1:0] sc;
	} entry_t;

	// Slot table points into a densely filled entry memory; a slot is live
	// only when its pointer is below the fill count and the entry points back.
	logic [IW-1:0] slot_tab [2**SW];
	entry_t        ent_mem [MAX_ENTRIES];
	logic [NW-1:0] hist_mem [NB];

	logic [IW-1:0]   ptr_rd_q;
	entry_t          ent_rd_q;
	logic [NW-1:0]   hist_rd_q;
	logic            ptr_lt_q;
	logic [SW-1:0]   probe_q;
	logic [KW-1:0]   key_q;
	logic            second_q;
	logic [NW-1:0]   count_q;
	logic [IW-1:0]   widx_q;
	logic [BW-1:0]   bin_q;
	logic [CW-1:0]   a_q;
	logic [CW-1:0]   c_q;
	logic [NW-1:0]   dist_q;
	logic [tqpd_pkg::STAT_W-1:0] ins_status_q;
	logic            out_valid_q;
	logic [SW-1:0]   init_q;

	logic [SW-1:0]    hash;
	logic [CW-1:0]    sat;
	logic [SDW-1:0]   side;
	logic [2*SDW-1:0] side_sq;
	logic [BW-1:0]    nbins_m1;
	logic [CW-1:0]    wa;
	logic [CW-1:0]    wc;
	logic [2*SDW-1:0] wbin;
	logic             occupied;
	logic             hit;
	logic             full;
	logic [CW-1:0]    upd_cnt;
	logic [CW-1:0]    upd_inc;
	entry_t           ent_wdata;
	logic             ent_we;
	logic [IW-1:0]    ent_waddr;
	logic [IW-1:0]    ent_raddr;
	logic             out_free;

	always_comb begin
		hash = '0;
		for (int j = 0; j < NCH; j++) begin
			for (int b = 0; b < SW; b++) begin
				if (j * SW + b < KW) hash[b] = hash[b] ^ in_key[j * SW + b];
			end
		end
	end

	assign sat      = CW'(thr) + CW'(1);
	assign side     = SDW'(thr) + SDW'(2);
	assign side_sq  = {{SDW{1'b0}}, side} * {{SDW{1'b0}}, side};
	assign nbins_m1 = BW'(side_sq - (2*SDW)'(1));

	// Counts written under a higher threshold read back as saturated.
	assign wa   = (ent_rd_q.fc > sat) ? sat : ent_rd_q.fc;
	assign wc   = (ent_rd_q.sc > sat) ? sat : ent_rd_q.sc;
	assign wbin = {{SDW{1'b0}}, SDW'(wa)} * {{SDW{1'b0}}, side} + (2*SDW)'(wc);

	assign occupied = ptr_lt_q && (ent_rd_q.slot == probe_q);
	assign hit      = occupied && (ent_rd_q.key == key_q);
	assign full     = (count_q == NW'(MAX_ENTRIES));
	assign out_free = !out_valid_q || out_ch.ready;

	assign upd_cnt = second_q ? ent_rd_q.sc : ent_rd_q.fc;
	assign upd_inc = (upd_cnt < sat) ? upd_cnt + CW'(1) : upd_cnt;

	always_comb begin
		ent_wdata.key  = key_q;
		ent_wdata.slot = probe_q;
		ent_we    = 1'b0;
		ent_waddr = count_q[IW-1:0];
		if (hit) begin
			ent_wdata.fc = second_q ? ent_rd_q.fc : upd_inc;
			ent_wdata.sc = second_q ? upd_inc : ent_rd_q.sc;
			ent_waddr = ptr_rd_q;
			ent_we = cmd.probe_eval;
		end else begin
			ent_wdata.fc = second_q ? CW'(0) : CW'(1);
			ent_wdata.sc = second_q ? CW'(1) : CW'(0);
			ent_we = cmd.probe_eval && !occupied && !full;
		end
	end

	assign ent_raddr = cmd.walk_rd ? widx_q : ptr_rd_q;

	always_ff @(posedge clk) begin
		if (ent_we) ent_mem[ent_waddr] <= ent_wdata;
		if (cmd.ent_rd_probe || cmd.walk_rd) ent_rd_q <= ent_mem[ent_raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.init_wr) slot_tab[init_q] <= '0;
		else if (cmd.probe_eval && !occupied && !full) slot_tab[probe_q] <= count_q[IW-1:0];
		if (cmd.slot_rd) ptr_rd_q <= slot_tab[probe_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) init_q <= '0;
		else if (cmd.init_wr) init_q <= init_q + SW'(1);
	end

	always_ff @(posedge clk) begin
		if (cmd.clr) hist_mem[bin_q] <= '0;
		else if (cmd.walk_wr) hist_mem[bin_q] <= hist_rd_q + NW'(1);
		if (cmd.hist_rd) hist_rd_q <= hist_mem[bin_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.ins_start) begin
			key_q    <= in_key;
			second_q <= in_second;
			probe_q  <= hash;
		end else if (cmd.probe_eval && occupied && !hit) begin
			probe_q <= probe_q + SW'(1);
		end
		if (cmd.ent_rd_probe) ptr_lt_q <= ({1'b0, ptr_rd_q} < count_q);
		if (cmd.probe_eval) begin
			if (hit) ins_status_q <= tqpd_pkg::INS_HIT;
			else if (full) ins_status_q <= tqpd_pkg::INS_FULL;
			else ins_status_q <= tqpd_pkg::INS_NEW;
		end
		if (cmd.rpt_start) begin
			widx_q <= '0;
			dist_q <= '0;
			a_q    <= '0;
			c_q    <= '0;
			bin_q  <= '0;
		end else if (cmd.clr) begin
			bin_q <= (bin_q == nbins_m1) ? '0 : bin_q + BW'(1);
		end else if (cmd.walk_bin) begin
			bin_q <= BW'(wbin);
			if (wa != wc) dist_q <= dist_q + NW'(1);
		end else if (cmd.walk_wr) begin
			widx_q <= widx_q + IW'(1);
			if (sts.walk_done) bin_q <= '0;
		end else if (cmd.emit_out) begin
			bin_q <= bin_q + BW'(1);
			if (c_q == sat) begin
				c_q <= '0;
				a_q <= a_q + CW'(1);
			end else begin
				c_q <= c_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) count_q <= '0;
		else if (cmd.probe_eval && !occupied && !full) count_q <= count_q + NW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.ins_out || cmd.emit_out) out_valid_q <= 1'b1;
		else if (out_ch.ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.ins_out) begin
			out_ch.result_kind      <= tqpd_pkg::KIND_INSERT;
			out_ch.insert_status    <= ins_status_q;
			out_ch.distance         <= '0;
			out_ch.entry_count      <= tqpd_pkg::TOT_W'(count_q);
			out_ch.bin_first_count  <= '0;
			out_ch.bin_second_count <= '0;
			out_ch.bin_total        <= '0;
			out_ch.last             <= 1'b1;
		end else if (cmd.emit_out) begin
			out_ch.result_kind      <= tqpd_pkg::KIND_BIN;
			out_ch.insert_status    <= tqpd_pkg::INS_NEW;
			out_ch.distance         <= tqpd_pkg::TOT_W'(dist_q);
			out_ch.entry_count      <= tqpd_pkg::TOT_W'(count_q);
			out_ch.bin_first_count  <= tqpd_pkg::BCNT_W'(a_q);
			out_ch.bin_second_count <= tqpd_pkg::BCNT_W'(c_q);
			out_ch.bin_total        <= tqpd_pkg::TOT_W'(hist_rd_q);
			out_ch.last             <= (bin_q == nbins_m1);
		end
	end

	assign out_ch.valid = out_valid_q;

	assign sts.init_done = (init_q == '1);
	assign sts.occupied  = occupied;
	assign sts.hit       = hit;
	assign sts.empty     = (count_q == '0);
	assign sts.clr_done  = (bin_q == nbins_m1);
	assign sts.walk_done = ((NW'(widx_q) + NW'(1)) == count_q);
	assign sts.out_free  = out_free;
	assign sts.emit_last = (bin_q == nbins_m1);

	`TQPD_ASSERT_SAME(a_count_bound, clk, arst_n, 1'b1, count_q <= NW'(MAX_ENTRIES),
		"entry count above table size")
	`TQPD_ASSERT_NEXT(a_hit_no_alloc, clk, arst_n, cmd.probe_eval && hit,
		count_q == $past(count_q), "hit allocated a new entry")
	`TQPD_ASSERT_NEXT(a_emit_wrap, clk, arst_n, cmd.emit_out && sts.emit_last,
		bin_q == '0 || (bin_q == $past(bin_q) + BW'(1)), "bin index lost its place")
	`TQPD_ASSERT_SAME(a_out_while_busy, clk, arst_n, cmd.ins_out || cmd.emit_out,
		out_free, "result loaded over a pending transaction")
endmodule
`default_nettype wire

### rtl/threshold_qgram_profile_distance.sv
// Insert: after acceptance, each hash probe reads the slot, reads the entry and checks it;
//   probes run one after another through the slot table port, then the result is loaded.
// Report: a clear of all B bins, a read, bin and histogram update per stored entry, then
//   a histogram read and a result per bin, B = (threshold+2)^2.
// One item is worked at a time; the result register lets the next be taken.
// Async active-low reset empties the table, threshold 2; a clear of all 2048 slots follows.
//------------------------------------------------------------------------------
// threshold_qgram_profile_distance
// Thresholded q-gram profile distance with APB threshold register.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module threshold_qgram_profile_distance #(
	parameter int MAX_ENTRIES   = tqpd_pkg::MAX_ENTRIES_DEF,
	parameter int MAX_THRESHOLD = tqpd_pkg::MAX_THRESHOLD_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	tqpd_in_if.sink   in_ch,
	tqpd_out_if.source out_ch,
	input  wire logic psel,
	input  wire logic penable,
	input  wire logic pwrite,
	input  wire logic [tqpd_pkg::PADDR_W-1:0] paddr,
	input  wire logic [tqpd_pkg::PDATA_W-1:0] pwdata,
	output logic [tqpd_pkg::PDATA_W-1:0] prdata,
	output logic pready
);
	localparam int TW = $clog2(MAX_THRESHOLD + 1);

	logic [tqpd_pkg::THR_W-1:0] thr_q;
	logic [TW-1:0] thr_eff;
	tqpd_pkg::cmd_t cmd;
	tqpd_pkg::sts_t sts;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) thr_q <= tqpd_pkg::THRESHOLD_RESET;
		else if (psel && penable && pwrite && paddr == tqpd_pkg::ADDR_THRESHOLD)
			thr_q <= pwdata[tqpd_pkg::THR_W-1:0];
	end

	assign prdata = (paddr == tqpd_pkg::ADDR_THRESHOLD)
		? {{(tqpd_pkg::PDATA_W-tqpd_pkg::THR_W){1'b0}}, thr_q} : '0;

	assign thr_eff = (32'(thr_q) > MAX_THRESHOLD) ? TW'(MAX_THRESHOLD) : TW'(thr_q);

	tqpd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_op    (in_ch.operation),
		.in_ready (in_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tqpd_dp #(
		.MAX_ENTRIES   (MAX_ENTRIES),
		.MAX_THRESHOLD (MAX_THRESHOLD)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.thr       (thr_eff),
		.in_key    (in_ch.qgram_key),
		.in_second (in_ch.second_string),
		.out_ch    (out_ch)
	);
endmodule
`default_nettype wire

### bench/tb.sv
//------------------------------------------------------------------------------
// Thresholded q-gram profile distance testbench
// Drives inserts and reports through the input channel, programs the threshold
// over the register port, and compares every result against a behavioral
// count table kept in the bench.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb;
	localparam int NUM_SLOTS = 1024;
	localparam int MAX_THR = 6;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic kind;
		logic [tqpd_pkg::STAT_W-1:0] status;
		logic [tqpd_pkg::TOT_W-1:0] distance;
		logic [tqpd_pkg::TOT_W-1:0] count;
		logic [tqpd_pkg::BCNT_W-1:0] b1;
		logic [tqpd_pkg::BCNT_W-1:0] b2;
		logic [tqpd_pkg::TOT_W-1:0] total;
		logic last;
	} result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [tqpd_pkg::PADDR_W-1:0] paddr = '0;
	logic [tqpd_pkg::PDATA_W-1:0] pwdata = '0;
	logic [tqpd_pkg::PDATA_W-1:0] prdata;
	logic pready;

	tqpd_in_if in_ch();
	tqpd_out_if out_ch();

	threshold_qgram_profile_distance uut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	// Bench copy of the count table.
	logic [63:0] tbl_key[NUM_SLOTS];
	logic [2:0] tbl_first[NUM_SLOTS];
	logic [2:0] tbl_second[NUM_SLOTS];
	int tbl_used = 0;
	logic [2:0] thr_reg = tqpd_pkg::THRESHOLD_RESET;

	result_t pending_results[$];
	int mismatches = 0;
	int idle_cycles = 0;
	bit stall_hold = 0;
	int hold_cycles = 0;

	initial begin
		in_ch.valid = 1'b0;
		in_ch.operation = tqpd_pkg::OP_INSERT;
		in_ch.qgram_key = '0;
		in_ch.second_string = 1'b0;
		out_ch.ready = 1'b0;
	end

	function automatic void predict_item(logic op, logic [63:0] key, logic second);
		int t, sat, side, dist_n, i, a, c;
		result_t r;
		int hist[64];
		bit found;
		t = (thr_reg > MAX_THR) ? MAX_THR : thr_reg;
		sat = t + 1;
		r = '0;
		if (op == tqpd_pkg::OP_INSERT) begin
			found = 0;
			r.status = tqpd_pkg::INS_FULL;
			for (i = 0; i < tbl_used; i++) begin
				if (!found && tbl_key[i] == key) begin
					found = 1;
					if (second) begin
						if (tbl_second[i] < sat) tbl_second[i]++;
					end else begin
						if (tbl_first[i] < sat) tbl_first[i]++;
					end
					r.status = tqpd_pkg::INS_HIT;
				end
			end
			if (!found && tbl_used < NUM_SLOTS) begin
				tbl_key[tbl_used] = key;
				tbl_first[tbl_used] = second ? 3'd0 : 3'd1;
				tbl_second[tbl_used] = second ? 3'd1 : 3'd0;
				tbl_used++;
				r.status = tqpd_pkg::INS_NEW;
			end
			r.kind = tqpd_pkg::KIND_INSERT;
			r.count = tqpd_pkg::TOT_W'(tbl_used);
			r.last = 1'b1;
			pending_results.push_back(r);
		end else begin
			side = t + 2;
			dist_n = 0;
			for (i = 0; i < 64; i++) hist[i] = 0;
			for (i = 0; i < tbl_used; i++) begin
				a = (tbl_first[i] > sat) ? sat : tbl_first[i];
				c = (tbl_second[i] > sat) ? sat : tbl_second[i];
				if (a != c) dist_n++;
				hist[a * side + c]++;
			end
			for (i = 0; i < side * side; i++) begin
				r = '0;
				r.kind = tqpd_pkg::KIND_BIN;
				r.distance = tqpd_pkg::TOT_W'(dist_n);
				r.count = tqpd_pkg::TOT_W'(tbl_used);
				r.b1 = tqpd_pkg::BCNT_W'(i / side);
				r.b2 = tqpd_pkg::BCNT_W'(i % side);
				r.total = tqpd_pkg::TOT_W'(hist[i]);
				r.last = (i == side * side - 1);
				pending_results.push_back(r);
			end
		end
	endfunction

	task automatic send_item(logic op, logic [63:0] key, logic second, bit no_gap = 0);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 12);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.operation <= op;
		in_ch.qgram_key <= key;
		in_ch.second_string <= second;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		predict_item(op, key, second);
	endtask

	task automatic write_threshold(logic [2:0] value);
		in_ch.valid <= 1'b0;
		// Every item leaves results, so an empty queue means the block is idle.
		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= tqpd_pkg::ADDR_THRESHOLD; pwdata <= tqpd_pkg::PDATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		thr_reg = value;
	endtask

	// Result side: random stalls, plus a long hold-off while the sender keeps going.
	always @(posedge clk) begin
		if (stall_hold) begin
			out_ch.ready <= 1'b0;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ch.ready <= 1'b0;
		end else if (out_ch.valid && out_ch.ready) begin
			hold_cycles <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 12) : 0;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		result_t got, want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = '{out_ch.result_kind, out_ch.insert_status, out_ch.distance,
				out_ch.entry_count, out_ch.bin_first_count, out_ch.bin_second_count,
				out_ch.bin_total, out_ch.last};
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", got);
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) $display("mismatch: expected %p, actual %p", want, got);
				end
			end
		end
	end

	// Watchdog on cycles with no transaction on either channel and no forced stall.
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || stall_hold)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic logic [63:0] rand_key();
		return {$urandom, $urandom};
	endfunction

	task automatic test_directed();
		send_item(tqpd_pkg::OP_REPORT, '0, 1'b0);
		send_item(tqpd_pkg::OP_INSERT, 64'd0, 1'b0);
		send_item(tqpd_pkg::OP_INSERT, '1, 1'b1);
		send_item(tqpd_pkg::OP_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
		send_item(tqpd_pkg::OP_INSERT, 64'h5555_5555_5555_5555, 1'b1);
		repeat (5) send_item(tqpd_pkg::OP_INSERT, 64'd0, 1'b0);
		send_item(tqpd_pkg::OP_INSERT, 64'd0, 1'b1);
		send_item(tqpd_pkg::OP_INSERT, '1, 1'b1);
		send_item(tqpd_pkg::OP_REPORT, '1, 1'b1);
	endtask

	task automatic test_threshold_sweep();
		logic [2:0] v;
		int k;
		// Lowering after counting clamps stored counts; 7 reads as the maximum.
		for (k = 0; k < 4; k++) begin
			case (k)
				0: v = 3'd0;
				1: v = 3'd7;
				2: v = 3'd6;
				default: v = 3'd1;
			endcase
			write_threshold(v);
			send_item(tqpd_pkg::OP_REPORT, rand_key(), 1'($urandom_range(0, 1)));
			repeat (6) send_item(tqpd_pkg::OP_INSERT, 64'd0, 1'($urandom_range(0, 1)));
			send_item(tqpd_pkg::OP_REPORT, rand_key(), 1'($urandom_range(0, 1)));
		end
		write_threshold(3'd2);
	endtask

	task automatic test_backpressure();
		int k;
		fork
			begin
				stall_hold = 1;
				repeat (300) @(posedge clk);
				stall_hold = 0;
			end
			for (k = 0; k < 12; k++)
				send_item(tqpd_pkg::OP_INSERT, rand_key() & 64'hF, k[0], 1);
		join
	endtask

	task automatic test_random(int n);
		logic [63:0] pool[16];
		int k;
		for (k = 0; k < 16; k++) pool[k] = rand_key();
		for (k = 0; k < n; k++) begin
			if ($urandom_range(0, 19) == 0)
				send_item(tqpd_pkg::OP_REPORT, rand_key(), 1'($urandom_range(0, 1)));
			else if ($urandom_range(0, 2) == 0)
				send_item(tqpd_pkg::OP_INSERT, rand_key(), 1'($urandom_range(0, 1)));
			else
				send_item(tqpd_pkg::OP_INSERT, pool[$urandom_range(0, 15)],
					1'($urandom_range(0, 1)));
			if (k == n / 2) write_threshold(3'($urandom_range(0, 7)));
		end
		send_item(tqpd_pkg::OP_REPORT, '0, 1'b0);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_threshold_sweep();
		test_backpressure();
		test_random(200);
		in_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
